>>> hdl/sgll_pkg.sv
// sgll_pkg: shared types, widths and register codes for the spherical
// gaussian log-likelihood block
// no dependencies
`default_nettype none

package sgll_pkg;

  localparam int NUM_FEATURES   = 4;
  localparam int NUM_COMPONENTS = 3;
  localparam int MAX_FEAT       = 4;
  localparam int MAX_COMP       = 3;

  localparam int FEAT_W    = 16;
  localparam int DIFF_W    = FEAT_W + 1;
  localparam int SQ_W      = 32;
  localparam int SUM_W     = SQ_W + 2;
  localparam int CHOL_W    = 16;
  localparam int CHSQ_W    = 2 * CHOL_W;
  localparam int BIAS_W    = 32;
  localparam int PLO_W     = CHSQ_W + SQ_W;
  localparam int PHI_W     = CHSQ_W + SUM_W - SQ_W;
  localparam int FRAC_SH   = 17;
  localparam int Q_W       = 50;
  localparam int DIFF_RES_W = Q_W + 1;
  localparam int LL_W      = 48;
  localparam int MEAN_W    = 64;
  localparam int SCALE_W   = 48;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int NSTG      = 6;

  localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(256);

  typedef logic signed [FEAT_W-1:0] feat_t;
  typedef logic signed [LL_W-1:0]   loglik_t;
  typedef feat_t [MAX_FEAT-1:0]     feat_vec_t;
  typedef logic [MAX_COMP-1:0][MEAN_W-1:0]  mean_arr_t;
  typedef logic [MAX_COMP-1:0][SCALE_W-1:0] scale_arr_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MEAN0  = 3'd0,
    REG_MEAN1  = 3'd1,
    REG_MEAN2  = 3'd2,
    REG_SCALE0 = 3'd3,
    REG_SCALE1 = 3'd4,
    REG_SCALE2 = 3'd5
  } reg_idx_t;

  // per-stage load enables shared by the control and every lane
  typedef struct packed {
    logic [NSTG-1:0] en;
  } pipe_ctl_t;

endpackage

`default_nettype wire

>>> hdl/sgll_in_if.sv
// sgll_in_if: sample request channel (valid/ready and four features)
// depends on sgll_pkg
`default_nettype none

interface sgll_in_if;
  import sgll_pkg::*;
  logic  valid;
  logic  ready;
  feat_t feat0;
  feat_t feat1;
  feat_t feat2;
  feat_t feat3;
  logic  last_in;

  modport source (output valid, feat0, feat1, feat2, feat3, last_in, input ready);
  modport sink   (input valid, feat0, feat1, feat2, feat3, last_in, output ready);
endinterface

`default_nettype wire

>>> hdl/sgll_out_if.sv
// sgll_out_if: result channel (valid/ready, three log-likelihoods, last flag)
// depends on sgll_pkg
`default_nettype none

interface sgll_out_if;
  import sgll_pkg::*;
  logic    valid;
  logic    ready;
  loglik_t loglik0;
  loglik_t loglik1;
  loglik_t loglik2;
  logic    last_out;

  modport source (output valid, loglik0, loglik1, loglik2, last_out, input ready);
  modport sink   (input valid, loglik0, loglik1, loglik2, last_out, output ready);
endinterface

`default_nettype wire

>>> hdl/sgll_cfg_if.sv
// sgll_cfg_if: configuration write channel (valid/ready, index, data)
// depends on sgll_pkg
`default_nettype none

interface sgll_cfg_if;
  import sgll_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hdl/sgll_cfg.sv
// sgll_cfg: mean and scale register file written over the config channel
// depends on sgll_pkg and sgll_cfg_if
`default_nettype none

module sgll_cfg import sgll_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  sgll_cfg_if.sink   cfg_s,
  output mean_arr_t  mean,
  output scale_arr_t scale
);

  mean_arr_t  mean_r, mean_nxt;
  scale_arr_t scale_r, scale_nxt;

  assign cfg_s.ready = 1'b1;

  always_comb begin
    mean_nxt  = mean_r;
    scale_nxt = scale_r;
    if (cfg_s.valid) begin
      case (cfg_s.index)
        REG_MEAN0:  mean_nxt[0]  = cfg_s.data;
        REG_MEAN1:  mean_nxt[1]  = cfg_s.data;
        REG_MEAN2:  mean_nxt[2]  = cfg_s.data;
        REG_SCALE0: scale_nxt[0] = cfg_s.data[SCALE_W-1:0];
        REG_SCALE1: scale_nxt[1] = cfg_s.data[SCALE_W-1:0];
        REG_SCALE2: scale_nxt[2] = cfg_s.data[SCALE_W-1:0];
        default: begin
          // unknown index, write dropped
          mean_nxt  = mean_r;
          scale_nxt = scale_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_COMP; k++) begin
        mean_r[k]  <= '0;
        scale_r[k] <= SCALE_RST;
      end
    end else begin
      mean_r  <= mean_nxt;
      scale_r <= scale_nxt;
    end
  end

  assign mean  = mean_r;
  assign scale = scale_r;

endmodule

`default_nettype wire

>>> hdl/sgll_ctrl.sv
// sgll_ctrl: valid tracking and stage enables for the six-stage pipeline,
// carries the batch-end flag alongside; depends on sgll_pkg
`default_nettype none

module sgll_ctrl import sgll_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_last,
  output logic      in_ready,
  output logic      out_valid,
  output logic      out_last,
  input  logic      out_ready,
  output pipe_ctl_t ctl
);

  logic [NSTG-1:0] valid_r, valid_nxt;
  logic [NSTG-1:0] last_r;
  logic [NSTG-1:0] en;

  // a stage loads when it is empty or its content moves on
  always_comb begin
    en[NSTG-1] = !valid_r[NSTG-1] || out_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !valid_r[i] || en[i+1];
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (en[0]) valid_nxt[0] = in_valid;
    for (int i = 1; i < NSTG; i++) begin
      if (en[i]) valid_nxt[i] = valid_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) last_r[0] <= in_last;
    for (int i = 1; i < NSTG; i++) begin
      if (en[i]) last_r[i] <= last_r[i-1];
    end
  end

  assign ctl.en    = en;
  assign in_ready  = en[0];
  assign out_valid = valid_r[NSTG-1];
  assign out_last  = last_r[NSTG-1];

`ifndef SYNTHESIS
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> &valid_r)
    else $error("input blocked with a bubble in the pipeline");

  a_drain_moves_all: assert property (@(posedge clk) disable iff (!rst_n)
    en[NSTG-1] |-> &en)
    else $error("output moving but an upstream stage held");

  a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[NSTG-1] && !out_ready |=> valid_r[NSTG-1] && $stable(last_r[NSTG-1]))
    else $error("stalled result lost or changed");

  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> valid_r[0])
    else $error("accepted request not captured in first stage");
`endif

endmodule

`default_nettype wire

>>> hdl/sgll_lane.sv
// sgll_lane: one mixture component, six registered stages from features to
// saturated Q32.16 log-likelihood; depends on sgll_pkg
`default_nettype none

module sgll_lane import sgll_pkg::*; (
  input  logic                clk,
  input  pipe_ctl_t           ctl,
  input  feat_vec_t           feat,
  input  logic [MEAN_W-1:0]   mean,
  input  logic [SCALE_W-1:0]  scale,
  output loglik_t             loglik
);

  localparam logic signed [DIFF_RES_W-1:0] SatMin = -(DIFF_RES_W'(1) <<< (LL_W - 1));
  localparam logic [PLO_W:0] RoundHalf = (PLO_W + 1)'(1) << (FRAC_SH - 1);

  // stage 0: differences, squared precision factor
  logic signed [DIFF_W-1:0] d_r [NUM_FEATURES];
  logic [CHSQ_W-1:0]        a0_r, a1_r, a2_r;
  logic signed [BIAS_W-1:0] bias0_r, bias1_r, bias2_r, bias3_r, bias4_r;
  // stage 1..5
  logic [SQ_W-1:0]          sq_r [NUM_FEATURES];
  logic [SUM_W-1:0]         s_r, s_nxt;
  logic [PLO_W-1:0]         plo_r;
  logic [PHI_W-1:0]         phi_r;
  logic [Q_W-1:0]           q_r, q_nxt;
  loglik_t                  loglik_r, loglik_nxt;
  logic [CHOL_W-1:0]        chol;
  logic [PLO_W:0]           plo_rnd;
  logic signed [DIFF_RES_W-1:0] r;

  assign chol = scale[CHOL_W-1:0];

  for (genvar f = 0; f < NUM_FEATURES; f++) begin : g_feat
    logic signed [DIFF_W-1:0]  d_nxt;
    logic signed [2*DIFF_W-1:0] prod;
    assign d_nxt = DIFF_W'($signed(feat[f])) -
                   DIFF_W'($signed(mean[FEAT_W*f +: FEAT_W]));
    assign prod  = d_r[f] * d_r[f];
    always_ff @(posedge clk) begin
      if (ctl.en[0]) d_r[f]  <= d_nxt;
      // square of a 17-bit difference stays below 2^32
      if (ctl.en[1]) sq_r[f] <= prod[SQ_W-1:0];
    end
  end

  always_comb begin
    s_nxt = '0;
    for (int f = 0; f < NUM_FEATURES; f++) begin
      s_nxt = s_nxt + SUM_W'(sq_r[f]);
    end
  end

  // q = round(a*s / 2^17), product split at bit 32 of s
  assign plo_rnd = (PLO_W + 1)'(plo_r) + RoundHalf;
  assign q_nxt   = (Q_W'(phi_r) << (SQ_W - FRAC_SH)) + Q_W'(plo_rnd >> FRAC_SH);
  assign r       = DIFF_RES_W'(bias4_r) - $signed({1'b0, q_r});
  assign loglik_nxt = (r < SatMin) ? SatMin[LL_W-1:0] : r[LL_W-1:0];

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      a0_r    <= CHSQ_W'(chol * chol);
      bias0_r <= $signed(scale[SCALE_W-1:CHOL_W]);
    end
    if (ctl.en[1]) begin
      a1_r    <= a0_r;
      bias1_r <= bias0_r;
    end
    if (ctl.en[2]) begin
      s_r     <= s_nxt;
      a2_r    <= a1_r;
      bias2_r <= bias1_r;
    end
    if (ctl.en[3]) begin
      plo_r   <= a2_r * s_r[SQ_W-1:0];
      phi_r   <= PHI_W'(a2_r * s_r[SUM_W-1:SQ_W]);
      bias3_r <= bias2_r;
    end
    if (ctl.en[4]) begin
      q_r     <= q_nxt;
      bias4_r <= bias3_r;
    end
    if (ctl.en[5]) loglik_r <= loglik_nxt;
  end

  assign loglik = loglik_r;

endmodule

`default_nettype wire

>>> hdl/spherical_gaussian_log_likelihood.sv
// spherical_gaussian_log_likelihood: top level, config registers, pipeline
// control and one lane per mixture component, merged into one result
// depends on sgll_pkg, sgll_*_if, sgll_cfg, sgll_ctrl, sgll_lane
//
//   channel  dir  handshake    payload
//   in_s     in   valid/ready  feat0..feat3 (Q8.8), last_in
//   out_s    out  valid/ready  loglik0..loglik2 (Q32.16), last_out
//   cfg_s    in   valid/ready  index (3 bits), data (64 bits)
//
// one request per cycle sustained while out_s.ready is high; the result passes through
// six register stages: difference, square, sum, split multiply, round, bias
// stages with no item are filled while a result waits on out_s.ready
// rst_n synchronous: pipeline empty, means 0, scale 1.0 with zero bias
// cfg_s is always ready; the write takes effect the next cycle
`default_nettype none

module spherical_gaussian_log_likelihood import sgll_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  sgll_in_if.sink     in_s,
  sgll_out_if.source  out_s,
  sgll_cfg_if.sink    cfg_s
);

  mean_arr_t  mean;
  scale_arr_t scale;
  pipe_ctl_t  ctl;
  feat_vec_t  feat;
  loglik_t    ll [MAX_COMP];

  sgll_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_s (cfg_s),
    .mean  (mean),
    .scale (scale)
  );

  sgll_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_s.valid),
    .in_last   (in_s.last_in),
    .in_ready  (in_s.ready),
    .out_valid (out_s.valid),
    .out_last  (out_s.last_out),
    .out_ready (out_s.ready),
    .ctl       (ctl)
  );

  assign feat[0] = in_s.feat0;
  assign feat[1] = in_s.feat1;
  assign feat[2] = in_s.feat2;
  assign feat[3] = in_s.feat3;

  for (genvar k = 0; k < MAX_COMP; k++) begin : g_comp
    if (k < NUM_COMPONENTS) begin : g_lane
      sgll_lane u_lane (
        .clk    (clk),
        .ctl    (ctl),
        .feat   (feat),
        .mean   (mean[k]),
        .scale  (scale[k]),
        .loglik (ll[k])
      );
    end else begin : g_off
      assign ll[k] = '0;
    end
  end

  // merge the lanes into one result
  assign out_s.loglik0 = ll[0];
  assign out_s.loglik1 = ll[1];
  assign out_s.loglik2 = ll[2];

endmodule

`default_nettype wire
